>>> sv/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
package ffha_pkg;

    localparam int OFFSET_W = 22;
    localparam int SIZE_W   = 23;
    localparam int ALIGN_W  = 4;
    localparam int NEED_W   = 24;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // Cell update codes
    localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_USED   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_FREE   = 3'd2;
    localparam logic [OP_W-1:0] OP_SPLIT      = 3'd3;
    localparam logic [OP_W-1:0] OP_TAKE_PIECE = 3'd4;
    localparam logic [OP_W-1:0] OP_TAKE_LEFT  = 3'd5;
    localparam logic [OP_W-1:0] OP_MERGE      = 3'd6;
    localparam logic [OP_W-1:0] OP_TAKE_RIGHT = 3'd7;

    typedef struct packed {
        logic                valid;
        logic [OFFSET_W-1:0] start;
        logic [OFFSET_W-1:0] bytes;
        logic                free;
    } t_blk;

    typedef struct packed {
        logic [NEED_W-1:0]   need;
        logic [OFFSET_W-1:0] off;
    } t_req;

    typedef struct packed {
        logic fit;
        logic split_ok;
        logic match;
    } t_flags;

endpackage

>>> sv/ffha_cell.sv
// One table entry of the allocator chain: holds a block and updates from its neighbours.
module ffha_cell #(
    parameter int HEAP_BYTES      = 4194304,
    parameter int HEADER_BYTES    = 24,
    parameter int MIN_SPLIT_BYTES = 8,
    parameter bit FIRST           = 1'b0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ffha_pkg::t_req            i_req,
    input  logic [ffha_pkg::OP_W-1:0] i_op,
    input  ffha_pkg::t_blk            i_left,
    input  ffha_pkg::t_blk            i_left_piece,
    input  ffha_pkg::t_blk            i_right,
    output ffha_pkg::t_blk            o_blk,
    output ffha_pkg::t_blk            o_piece,
    output ffha_pkg::t_flags          o_flags
);

    localparam int W = ffha_pkg::NEED_W + 1;
    localparam logic [W-1:0] HDR     = W'(HEADER_BYTES);
    localparam logic [W-1:0] HDR_MIN = W'(HEADER_BYTES + MIN_SPLIT_BYTES);

    ffha_pkg::t_blk r_blk, n_blk, w_reset;

    always_comb begin
        w_reset = '0;
        if (FIRST) begin
            w_reset.valid = 1'b1;
            w_reset.bytes = ffha_pkg::OFFSET_W'(HEAP_BYTES - HEADER_BYTES);
            w_reset.free  = 1'b1;
        end
    end

    always_comb begin
        o_flags.fit      = r_blk.valid && r_blk.free
                           && (W'(r_blk.bytes) >= W'(i_req.need));
        o_flags.split_ok = W'(r_blk.bytes) >= W'(i_req.need) + HDR_MIN;
        o_flags.match    = r_blk.valid
                           && (W'(r_blk.start) + HDR == W'(i_req.off));
        // leftover block that a split hands to the right neighbour
        o_piece.valid = 1'b1;
        o_piece.start = ffha_pkg::OFFSET_W'(W'(r_blk.start) + HDR + W'(i_req.need));
        o_piece.bytes = ffha_pkg::OFFSET_W'(W'(r_blk.bytes) - W'(i_req.need) - HDR);
        o_piece.free  = 1'b1;
    end

    always_comb begin
        n_blk = r_blk;
        case (i_op)
            ffha_pkg::OP_SET_USED:   n_blk.free = 1'b0;
            ffha_pkg::OP_SET_FREE:   n_blk.free = 1'b1;
            ffha_pkg::OP_SPLIT: begin
                n_blk.bytes = ffha_pkg::OFFSET_W'(i_req.need);
                n_blk.free  = 1'b0;
            end
            ffha_pkg::OP_TAKE_PIECE: n_blk = i_left_piece;
            ffha_pkg::OP_TAKE_LEFT:  n_blk = i_left;
            ffha_pkg::OP_MERGE: begin
                n_blk.bytes = ffha_pkg::OFFSET_W'(W'(r_blk.bytes) + HDR + W'(i_right.bytes));
                n_blk.free  = 1'b1;
            end
            ffha_pkg::OP_TAKE_RIGHT: n_blk = i_right;
            default:                 n_blk = r_blk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= w_reset;
        end else begin
            r_blk <= n_blk;
        end
    end

    assign o_blk = r_blk;

endmodule

>>> sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: handshakes, pick logic and the cell chain.
// Usage:
// Input channel i_in_valid / o_in_ready carries one command per transaction:
// allocate (size, alignment) or release (payload offset).
// Output channel o_out_valid / i_out_ready returns one result per command:
// payload offset (0 unless an allocate succeeded) and a status code.
// Each table entry lives in its own cell; all cells compare against the
// request in parallel, a priority chain picks the first hit (EVAL cycle),
// and in the APPLY cycle the chain shifts right for a split or left for a
// merge, every cell past the hit taking its neighbour's contents at once.
// After acceptance a command passes EVAL, then APPLY, which loads the output register.
// A new command is taken in the APPLY cycle of the previous one.
// If the receiver stalls, the result waits in the output register; the next
// command is still accepted but holds in EVAL until the register frees.
// Reset leaves one free block covering the heap, less one header.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES      = 4194304,
    parameter int HEADER_BYTES    = 24,
    parameter int MAX_BLOCKS      = 64,
    parameter int MIN_SPLIT_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [ffha_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ffha_pkg::ALIGN_W-1:0]  i_align_log2,
    input  logic [ffha_pkg::OFFSET_W-1:0] i_payload_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ffha_pkg::OFFSET_W-1:0] o_result_offset,
    output logic [ffha_pkg::STATUS_W-1:0] o_status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    localparam int N  = MAX_BLOCKS;
    localparam int OW = ffha_pkg::OFFSET_W;
    localparam int AM = 1 << ffha_pkg::ALIGN_W;

    logic [1:0]  r_state, n_state;
    logic        r_cmd;
    ffha_pkg::t_req r_req;

    ffha_pkg::t_blk   w_blk   [N];
    ffha_pkg::t_blk   w_piece [N];
    ffha_pkg::t_flags w_flags [N];
    logic [ffha_pkg::OP_W-1:0] w_op [N];

    logic [N-1:0] w_hit, w_pre, w_first, w_valid;
    logic [N-1:0] r_first, r_pre;
    logic         r_found, r_split, r_merge;
    logic [OW-1:0] r_start_sel;
    logic         w_split, w_merge;
    logic [OW-1:0] w_start_sel;

    logic          r_out_valid;
    logic [OW-1:0] r_out_offset;
    logic [ffha_pkg::STATUS_W-1:0] r_out_status;

    logic w_accept, w_eval_go;
    logic [AM-1:0] w_mask;
    logic [ffha_pkg::NEED_W-1:0] w_need;

    // nothing is taken while reset is held
    assign o_in_ready = i_rst_n && ((r_state == S_IDLE) || (r_state == S_APPLY));
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_eval_go  = !r_out_valid || i_out_ready;

    // round size up to the alignment
    always_comb begin
        w_mask = (AM'(1) << i_align_log2) - AM'(1);
        w_need = (ffha_pkg::NEED_W'(i_request_size) + ffha_pkg::NEED_W'(w_mask))
                 & ~ffha_pkg::NEED_W'(w_mask);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EVAL;
            S_EVAL:  if (w_eval_go) n_state = S_APPLY;
            S_APPLY: n_state = w_accept ? S_EVAL : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_command;
            r_req.need  <= w_need;
            r_req.off   <= i_payload_offset;
        end
    end

    // cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        ffha_pkg::t_blk w_l, w_lp, w_r;
        if (g == 0) begin : g_l0
            assign w_l  = '0;
            assign w_lp = '0;
        end else begin : g_ln
            assign w_l  = w_blk[g-1];
            assign w_lp = w_piece[g-1];
        end
        if (g == N - 1) begin : g_rn
            assign w_r = '0;
        end else begin : g_r
            assign w_r = w_blk[g+1];
        end
        ffha_cell #(
            .HEAP_BYTES      (HEAP_BYTES),
            .HEADER_BYTES    (HEADER_BYTES),
            .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES),
            .FIRST           (g == 0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_req        (r_req),
            .i_op         (w_op[g]),
            .i_left       (w_l),
            .i_left_piece (w_lp),
            .i_right      (w_r),
            .o_blk        (w_blk[g]),
            .o_piece      (w_piece[g]),
            .o_flags      (w_flags[g])
        );
        assign w_valid[g] = w_blk[g].valid;
        assign w_hit[g]   = (r_cmd == ffha_pkg::CMD_RELEASE) ? w_flags[g].match
                                                               : w_flags[g].fit;
    end

    // first-hit pick
    always_comb begin
        w_pre[0] = 1'b0;
        for (int k = 1; k < N; k++) begin
            w_pre[k] = w_pre[k-1] | w_hit[k-1];
        end
        w_first     = w_hit & ~w_pre;
        w_split     = 1'b0;
        w_merge     = 1'b0;
        w_start_sel = '0;
        for (int k = 0; k < N; k++) begin
            if (w_first[k]) begin
                w_split     = w_flags[k].split_ok && !w_valid[N-1];
                w_start_sel = w_blk[k].start;
                if (k < N - 1) begin
                    w_merge = w_blk[(k < N - 1) ? k + 1 : k].valid
                              && w_blk[(k < N - 1) ? k + 1 : k].free;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_pre   <= '0;
            r_found <= 1'b0;
            r_split <= 1'b0;
            r_merge <= 1'b0;
        end else if (r_state == S_EVAL) begin
            r_first     <= w_first;
            r_pre       <= w_pre;
            r_found     <= |w_hit;
            r_split     <= w_split;
            r_merge     <= w_merge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_start_sel <= w_start_sel;
        end
    end

    // per-cell update codes
    for (genvar g = 0; g < N; g++) begin : g_op
        always_comb begin
            w_op[g] = ffha_pkg::OP_HOLD;
            if (r_state == S_APPLY && r_found) begin
                if (r_cmd == ffha_pkg::CMD_ALLOC) begin
                    if (r_first[g]) begin
                        w_op[g] = r_split ? ffha_pkg::OP_SPLIT : ffha_pkg::OP_SET_USED;
                    end else if (r_split && g > 0 && r_first[(g > 0) ? g - 1 : 0]) begin
                        w_op[g] = ffha_pkg::OP_TAKE_PIECE;
                    end else if (r_split && r_pre[g]) begin
                        w_op[g] = ffha_pkg::OP_TAKE_LEFT;
                    end
                end else begin
                    if (r_first[g]) begin
                        w_op[g] = r_merge ? ffha_pkg::OP_MERGE : ffha_pkg::OP_SET_FREE;
                    end else if (r_merge && r_pre[g]) begin
                        w_op[g] = ffha_pkg::OP_TAKE_RIGHT;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_APPLY) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            if (!r_found) begin
                r_out_offset <= '0;
                r_out_status <= (r_cmd == ffha_pkg::CMD_RELEASE) ? ffha_pkg::ST_BAD_FREE
                                                                  : ffha_pkg::ST_NO_FIT;
            end else begin
                r_out_offset <= (r_cmd == ffha_pkg::CMD_RELEASE) ? '0
                                : OW'((OW + 1)'(r_start_sel) + (OW + 1)'(HEADER_BYTES));
                r_out_status <= ffha_pkg::ST_OK;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_offset = r_out_offset;
    assign o_status        = r_out_status;

    // Entry 0 always holds a block
    a_first_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0])
        else $error("first table entry lost");

    // Valid entries form an unbroken prefix of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + N'(1))) == '0))
        else $error("gap in block table");

    // A fresh result only follows an APPLY cycle
    a_out_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_APPLY))
        else $error("result without a processed command");

    // APPLY is only entered with room in the output register
    a_apply_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> !r_out_valid)
        else $error("result register overrun");

endmodule
